// ===== hw/rtl/tgrq_pkg.sv =====
// Shared types and constants for the thresholded grid region query block.
// Used by tgrq_div and thresholded_grid_region_query. No dependencies.
`timescale 1ns / 1ps

package tgrq_pkg;

  // Query position and cell size widths, Q16.16.
  localparam int unsigned PosW  = 32;
  localparam int unsigned SizeW = 31;
  // Signed quotient of a 32 bit position by a cell size of at least one.
  localparam int unsigned QuotW = PosW + 1;

  localparam int unsigned NumFaces = 6;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_INSIDE,
    OP_INTERIOR,
    OP_EXTERIOR
  } op_e;

  // Comparison modes of the threshold test.
  localparam logic [2:0] CMP_GT = 3'd0;
  localparam logic [2:0] CMP_GE = 3'd1;
  localparam logic [2:0] CMP_LT = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_EQ = 3'd4;
  localparam logic [2:0] CMP_NE = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_CELL_SIZE_X = 3'd0;
  localparam logic [2:0] REG_CELL_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_THRESHOLD   = 3'd3;
  localparam logic [2:0] REG_COMPARE     = 3'd4;
  localparam logic [2:0] REG_STORE_LO_X  = 3'd5;
  localparam logic [2:0] REG_STORE_LO_Y  = 3'd6;
  localparam logic [2:0] REG_STORE_LO_Z  = 3'd7;

endpackage

// ===== hw/rtl/tgrq_div.sv =====
// Iterative floor division of a signed position by an unsigned cell size.
// One quotient bit per cycle. Depends on tgrq_pkg.
`timescale 1ns / 1ps

module tgrq_div
  import tgrq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [PosW-1:0]  dividend_i,
  input  logic [SizeW-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [QuotW-1:0] quot_o,
  output logic [SizeW-1:0]        rem_o
);

  localparam int unsigned CntW = $clog2(PosW);
  localparam logic [CntW-1:0] CntLast = CntW'(PosW - 1);

  logic            run_q, done_q, neg_q;
  logic [CntW-1:0] cnt_q;
  logic [PosW-1:0] mag_q;
  logic [SizeW-1:0] rem_q, div_q;
  logic [PosW-1:0] trial;
  logic            ge;
  logic [QuotW-1:0] q0;

  assign trial = {rem_q, mag_q[PosW-1]};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      mag_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        neg_q <= dividend_i[PosW-1];
        mag_q <= dividend_i[PosW-1] ? (~dividend_i + 1'b1) : dividend_i;
        rem_q <= '0;
        div_q <= divisor_i;
        cnt_q <= '0;
      end else if (run_q) begin
        rem_q <= ge ? SizeW'(trial - {1'b0, div_q}) : SizeW'(trial);
        mag_q <= {mag_q[PosW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Negative dividends round toward minus infinity; ~q0 is -q0 - 1.
  assign q0     = {1'b0, mag_q};
  assign done_o = done_q;
  assign quot_o = !neg_q ? q0 : ((rem_q == '0) ? (~q0 + 1'b1) : ~q0);
  assign rem_o  = (neg_q && rem_q != '0) ? (div_q - rem_q) : rem_q;

endmodule

// ===== hw/rtl/thresholded_grid_region_query.sv =====
// Top level of the thresholded grid region query block: grid store memory,
// query sequencer and result register. Depends on tgrq_pkg and tgrq_div.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   operation, cell_x/y/z, cell_value,
//                                                pos_x/y/z, cutoff
// out       output     out_valid_o / out_ready_i hit, distance, offset_x/y/z,
//                                                wall_index, last
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A write item is taken in the idle state; its acknowledgement sits in the
// result register while the next item may already be taken. A query keeps
// the input side closed from its acceptance until the sequencer is idle again:
// it starts the bit-serial floor dividers (one per axis, running in parallel,
// 32 steps) and takes their result, then reads each cell from the grid memory
// in a read state and evaluates it in an evaluation state (the center cell and
// up to six neighbors), then emits one result at a time, or leaves the emit
// step at once when a face search finds nothing to emit. The grid memory is
// not cleared by reset; a cell reads as undefined until it is written. A stalled
// result register holds the sequencer in its emit step until the item is taken.

module thresholded_grid_region_query
  import tgrq_pkg::*;
#(
  parameter int unsigned STORE_NX = 16,
  parameter int unsigned STORE_NY = 16,
  parameter int unsigned STORE_NZ = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              operation_i,
  input  logic [3:0]              cell_x_i,
  input  logic [3:0]              cell_y_i,
  input  logic [3:0]              cell_z_i,
  input  logic signed [31:0]      cell_value_i,
  input  logic signed [31:0]      pos_x_i,
  input  logic signed [31:0]      pos_y_i,
  input  logic signed [31:0]      pos_z_i,
  input  logic [30:0]             cutoff_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic [30:0]             distance_o,
  output logic signed [31:0]      offset_x_o,
  output logic signed [31:0]      offset_y_o,
  output logic signed [31:0]      offset_z_o,
  output logic [2:0]              wall_index_o,
  output logic                    last_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  localparam int unsigned Depth = STORE_NX * STORE_NY * STORE_NZ;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned XW    = $clog2(STORE_NX);
  localparam int unsigned YW    = $clog2(STORE_NY);
  localparam int unsigned ZW    = $clog2(STORE_NZ);
  // Store-relative index: quotient minus window low, plus a neighbor step.
  localparam int unsigned RelW  = QuotW + 2;
  localparam logic signed [RelW-1:0] NxS = RelW'(STORE_NX);
  localparam logic signed [RelW-1:0] NyS = RelW'(STORE_NY);
  localparam logic signed [RelW-1:0] NzS = RelW'(STORE_NZ);
  localparam logic [AW-1:0] RowStride   = AW'(STORE_NX);
  localparam logic [AW-1:0] PlaneStride = AW'(STORE_NX * STORE_NY);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CRD,
    ST_CEV,
    ST_FRD,
    ST_FEV,
    ST_EMIT
  } state_e;

  function automatic logic passes(input logic signed [31:0] v,
                                  input logic signed [31:0] thr,
                                  input logic [2:0] mode);
    logic r;
    case (mode)
      CMP_GT:  r = v > thr;
      CMP_GE:  r = v >= thr;
      CMP_LT:  r = v < thr;
      CMP_LE:  r = v <= thr;
      CMP_EQ:  r = v == thr;
      CMP_NE:  r = v != thr;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Configuration registers.
  logic [SizeW-1:0]   cs_q [3];
  logic signed [31:0] thr_q;
  logic [2:0]         mode_q;
  logic signed [10:0] lo_q [3];
  logic [SizeW-1:0]   s_eff [3];

  // Sequencer state.
  state_e             state_q;
  op_e                op_q;
  logic [30:0]        cut_q, best_q;
  logic [2:0]         face_q;
  logic [NumFaces-1:0] mask_q;
  logic               win_q, ctr_in_q;
  logic signed [RelW-1:0] rel_q [3];
  logic [SizeW-1:0]   rem_q [3];

  // Result register.
  logic               ovalid_q, hit_q, last_q;
  logic [30:0]        dist_q;
  logic signed [31:0] offx_q, offy_q, offz_q;
  logic [2:0]         wall_q;

  // Divider signals.
  logic               div_start;
  logic               div_done [3];
  logic signed [QuotW-1:0] div_quot [3];
  logic [SizeW-1:0]   div_rem [3];
  logic signed [31:0] pos_in [3];

  // Memory signals.
  logic [31:0]        mem_q [Depth];
  logic [31:0]        rdata_q;
  logic               mem_re, mem_we;
  logic [AW-1:0]      raddr, waddr;
  logic               wr_in_range;

  logic               in_acc, slot_free, cell_pass, out_load;
  logic signed [RelW-1:0] coord_c [3];
  logic               win_c;
  logic [30:0]        dist_c [NumFaces];
  logic [2:0]         sel_face;
  logic [NumFaces-1:0] mask_rest;
  logic [1:0]         sel_ax;
  logic signed [31:0] sel_off;

  assign cfg_ready_o = 1'b1;
  assign slot_free   = !ovalid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && slot_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign div_start   = in_acc && (op_e'(operation_i) != OP_WRITE);
  assign cell_pass   = passes(rdata_q, thr_q, mode_q);

  // The result register is loaded by a write acknowledgement or by the emit step.
  assign out_load = (in_acc && op_e'(operation_i) == OP_WRITE) ||
                    (state_q == ST_EMIT && slot_free &&
                     (op_q == OP_INSIDE || mask_q != '0));

  // A cell size of zero behaves as one LSB.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_eff[i] = (cs_q[i] == '0) ? SizeW'(1) : cs_q[i];
    end
  end

  assign pos_in[0] = pos_x_i;
  assign pos_in[1] = pos_y_i;
  assign pos_in[2] = pos_z_i;

  for (genvar g = 0; g < 3; g++) begin : g_div
    tgrq_div u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .start_i    (div_start),
      .dividend_i (pos_in[g]),
      .divisor_i  (s_eff[g]),
      .done_o     (div_done[g]),
      .quot_o     (div_quot[g]),
      .rem_o      (div_rem[g])
    );
  end

  // Cell addressed in the read states: the center, or the neighbor across face_q.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coord_c[i] = rel_q[i];
      if (state_q == ST_FRD && int'(face_q[2:1]) == i) begin
        coord_c[i] = face_q[0] ? rel_q[i] + RelW'(1) : rel_q[i] - RelW'(1);
      end
    end
    win_c = coord_c[0] >= 0 && coord_c[0] < NxS &&
            coord_c[1] >= 0 && coord_c[1] < NyS &&
            coord_c[2] >= 0 && coord_c[2] < NzS;
    raddr = AW'(coord_c[2][ZW-1:0]) * PlaneStride +
            AW'(coord_c[1][YW-1:0]) * RowStride + AW'(coord_c[0][XW-1:0]);
  end

  assign mem_re = (state_q == ST_CRD || state_q == ST_FRD) && win_c;

  assign wr_in_range = 9'(cell_x_i) < 9'(STORE_NX) && 9'(cell_y_i) < 9'(STORE_NY) &&
                       9'(cell_z_i) < 9'(STORE_NZ);
  assign mem_we = in_acc && op_e'(operation_i) == OP_WRITE && wr_in_range;
  assign waddr  = AW'(cell_z_i) * PlaneStride + AW'(cell_y_i) * RowStride + AW'(cell_x_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= cell_value_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Distance from the point to each face of its cell.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dist_c[2*i]   = rem_q[i];
      dist_c[2*i+1] = s_eff[i] - rem_q[i];
    end
  end

  // Lowest pending face in the emit step.
  always_comb begin
    sel_face = '0;
    for (int i = NumFaces - 1; i >= 0; i--) begin
      if (mask_q[i]) sel_face = 3'(i);
    end
    mask_rest = mask_q & ~(NumFaces'(1) << sel_face);
    sel_ax    = sel_face[2:1];
    sel_off   = sel_face[0] ? -$signed({1'b0, dist_c[sel_face]})
                            : $signed({1'b0, dist_c[sel_face]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q     <= '{default: SizeW'(65536)};
      thr_q    <= '0;
      mode_q   <= CMP_GT;
      lo_q     <= '{default: '0};
      state_q  <= ST_IDLE;
      op_q     <= OP_WRITE;
      cut_q    <= '0;
      best_q   <= '0;
      face_q   <= '0;
      mask_q   <= '0;
      win_q    <= 1'b0;
      ctr_in_q <= 1'b0;
      rel_q    <= '{default: '0};
      rem_q    <= '{default: '0};
      ovalid_q <= 1'b0;
      hit_q    <= 1'b0;
      last_q   <= 1'b0;
      dist_q   <= '0;
      offx_q   <= '0;
      offy_q   <= '0;
      offz_q   <= '0;
      wall_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_CELL_SIZE_X: cs_q[0] <= cfg_data_i[SizeW-1:0];
          REG_CELL_SIZE_Y: cs_q[1] <= cfg_data_i[SizeW-1:0];
          REG_CELL_SIZE_Z: cs_q[2] <= cfg_data_i[SizeW-1:0];
          REG_THRESHOLD:   thr_q   <= cfg_data_i;
          REG_COMPARE:     mode_q  <= cfg_data_i[2:0];
          REG_STORE_LO_X:  lo_q[0] <= cfg_data_i[10:0];
          REG_STORE_LO_Y:  lo_q[1] <= cfg_data_i[10:0];
          REG_STORE_LO_Z:  lo_q[2] <= cfg_data_i[10:0];
          default: ;
        endcase
      end

      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q  <= op_e'(operation_i);
            cut_q <= cutoff_i;
            if (op_e'(operation_i) == OP_WRITE) begin
              // Write acknowledgement: an empty result.
              hit_q    <= 1'b0;
              dist_q   <= '0;
              offx_q   <= '0;
              offy_q   <= '0;
              offz_q   <= '0;
              wall_q   <= '0;
              last_q   <= 1'b1;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done[0] && div_done[1] && div_done[2]) begin
            for (int i = 0; i < 3; i++) begin
              rel_q[i] <= RelW'(div_quot[i]) - RelW'(lo_q[i]);
              rem_q[i] <= div_rem[i];
            end
            state_q <= ST_CRD;
          end
        end
        ST_CRD: begin
          win_q   <= win_c;
          state_q <= ST_CEV;
        end
        ST_CEV: begin
          ctr_in_q <= win_q && cell_pass;
          face_q   <= '0;
          mask_q   <= '0;
          best_q   <= cut_q;
          case (op_q)
            OP_INSIDE:   state_q <= ST_EMIT;
            OP_INTERIOR: state_q <= (win_q && cell_pass) ? ST_FRD : ST_IDLE;
            OP_EXTERIOR: state_q <= (win_q && !cell_pass) ? ST_FRD : ST_IDLE;
            default:     state_q <= ST_IDLE;
          endcase
        end
        ST_FRD: begin
          win_q   <= win_c;
          state_q <= ST_FEV;
        end
        ST_FEV: begin
          if (op_q == OP_INTERIOR) begin
            if (dist_c[face_q] < cut_q && !(win_q && cell_pass)) begin
              mask_q[face_q] <= 1'b1;
            end
          end else if (dist_c[face_q] < best_q && win_q && cell_pass) begin
            // Strict compare keeps the first face on a tie.
            best_q <= dist_c[face_q];
            mask_q <= NumFaces'(1) << face_q;
          end
          if (face_q == 3'(NumFaces - 1)) begin
            state_q <= ST_EMIT;
          end else begin
            face_q  <= face_q + 1'b1;
            state_q <= ST_FRD;
          end
        end
        ST_EMIT: begin
          if (op_q == OP_INSIDE) begin
            if (slot_free) begin
              hit_q    <= ctr_in_q;
              dist_q   <= '0;
              offx_q   <= '0;
              offy_q   <= '0;
              offz_q   <= '0;
              wall_q   <= '0;
              last_q   <= 1'b1;
              state_q  <= ST_IDLE;
            end
          end else if (mask_q == '0) begin
            state_q <= ST_IDLE;
          end else if (slot_free) begin
            hit_q    <= 1'b1;
            dist_q   <= dist_c[sel_face];
            offx_q   <= (sel_ax == 2'd0) ? sel_off : '0;
            offy_q   <= (sel_ax == 2'd1) ? sel_off : '0;
            offz_q   <= (sel_ax == 2'd2) ? sel_off : '0;
            wall_q   <= (op_q == OP_EXTERIOR) ? 3'd0 : sel_face;
            last_q   <= (mask_rest == '0);
            mask_q   <= mask_rest;
            if (mask_rest == '0) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = ovalid_q;
  assign hit_o        = hit_q;
  assign distance_o   = dist_q;
  assign offset_x_o   = offx_q;
  assign offset_y_o   = offy_q;
  assign offset_z_o   = offz_q;
  assign wall_index_o = wall_q;
  assign last_o       = last_q;

  // The input side is closed while a query is being worked on.
  a_busy_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o)
    else $error("input accepted while a query is in progress");

  // Every cell evaluation comes in the cycle right after its memory read.
  a_read_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FEV || state_q == ST_CEV) |->
      ($past(state_q) == ST_FRD || $past(state_q) == ST_CRD))
    else $error("cell evaluated without a preceding read");

  // An exterior query keeps at most one candidate face.
  a_ext_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_q == OP_EXTERIOR |-> $onehot0(mask_q))
    else $error("exterior query holds several faces");

  // Emitted face codes stay within the six faces.
  a_wall_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> wall_index_o <= 3'd5)
    else $error("face code out of range");

endmodule
